[hdl/epoch_seconds_to_calendar_date_assert.svh]
// assertion macros shared by the epoch date converter modules
// expects clk and arst_n to be visible in the module that uses them
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// property checked on every clock outside reset
`define ES2CD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every clock outside reset
`define ES2CD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/es2cd_pkg.sv]
// shared constants, reciprocals and small tables for the epoch date converter
// no dependencies
`default_nettype none

package es2cd_pkg;

	// pipeline depth, input register to output register
	localparam int NSTG = 10;

	// seconds per day is 128 * 675: the low 7 bits pass through untouched
	localparam logic [29:0] DAY_RECIP = 30'd814453058;   // ceil(2^39 / 675)
	localparam logic [9:0]  DAY_UNITS = 10'd675;
	localparam int          EPOCH_DAYS = 719468;           // 0000-03-01 to 1970-01-01
	localparam int          DAYS_PER_ERA = 146097;         // days in 400 years
	localparam int          DAYS_PER_CENT = 36524;

	localparam logic [16:0] Q1460_RECIP = 17'd91930;      // ceil(2^25 / 365), on doe / 4
	localparam logic [18:0] YEAR_RECIP = 19'd367720;      // ceil(2^27 / 365)
	localparam logic [13:0] HOUR_RECIP = 14'd9321;        // ceil(2^21 / 225), on rem / 16
	localparam logic [10:0] MIN_RECIP = 11'd1093;         // ceil(2^14 / 15), on rem / 4
	// (5 * doy + 2) * ceil(2^19 / 153) folded into one multiply and add
	localparam logic [14:0] MONTH_MUL = 15'd17135;
	localparam logic [23:0] MONTH_ADD = 24'd6854;

	typedef struct packed {
		logic [NSTG-1:0] en;   // per-stage load enable
	} pipe_ctl_t;

	// day count at which era idx + 5 starts, counted from 1970-01-01
	function automatic logic [19:0] era_thr(input int idx);
		return 20'((idx + 5) * DAYS_PER_ERA - EPOCH_DAYS);
	endfunction

	// first day of era idx + 4 in the shifted day count
	function automatic logic [20:0] era_base(input logic [2:0] idx);
		return 21'((int'(idx) + 4) * DAYS_PER_ERA);
	endfunction

	// first year of era idx + 4
	function automatic logic [12:0] era_year(input logic [2:0] idx);
		return 13'((int'(idx) + 4) * 400);
	endfunction

	// day of the year, counted from 1 March, at which month index mp starts
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] res;
		unique case (mp)
			4'd0:    res = 9'd0;
			4'd1:    res = 9'd31;
			4'd2:    res = 9'd61;
			4'd3:    res = 9'd92;
			4'd4:    res = 9'd122;
			4'd5:    res = 9'd153;
			4'd6:    res = 9'd184;
			4'd7:    res = 9'd214;
			4'd8:    res = 9'd245;
			4'd9:    res = 9'd275;
			4'd10:   res = 9'd306;
			4'd11:   res = 9'd337;
			default: res = 9'd0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

[hdl/es2cd_ctrl.sv]
// valid tracking and per-stage load enables for the converter pipeline
// depends on es2cd_pkg and the assertion macro header
`default_nettype none
`include "epoch_seconds_to_calendar_date_assert.svh"

module es2cd_ctrl import es2cd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] can;
	logic [NSTG-1:0] vld_in;

	// a stage can load when it is empty or the stage after it moves
	always_comb begin
		can[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			can[k] = !vld_q[k] || can[k+1];
		end
	end

	assign vld_in = {vld_q[NSTG-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (can & vld_in) | (~can & vld_q);
		end
	end

	assign ctl.en    = can;
	assign in_ready  = can[0];
	assign out_valid = vld_q[NSTG-1];

	`ES2CD_ASSERT_IMP(a_bubble_ready, !(&vld_q), in_ready, "request refused with an empty stage")
	`ES2CD_ASSERT_IMP(a_drain_ready, out_ready, in_ready, "pipeline stalled while output drains")
	`ES2CD_ASSERT_IMP(a_item_count, $past(arst_n), $countones(vld_q) == $countones($past(vld_q)) + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)), "items lost or duplicated in pipeline")

endmodule

`default_nettype wire

[hdl/es2cd_time.sv]
// time-of-day lane: seconds within the day split into hour, minute, second
// depends on es2cd_pkg; takes the day count from the date lane
`default_nettype none

module es2cd_time import es2cd_pkg::*; (
	input  logic        clk,
	input  pipe_ctl_t   ctl,
	input  logic [16:0] sec_lo,
	input  logic [19:0] days_s1,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	logic [16:0] lo_s1, lo_s2;
	logic [9:0]  d675_s2;
	logic [16:0] rem_s3, rem_s4;
	logic [4:0]  hour_s4, hour_s5, hour_s6, hour_s7, hour_s8, hour_s9, hour_s10;
	logic [11:0] r2_s5, r2_s6;
	logic [5:0]  minute_s6, minute_s7, minute_s8, minute_s9, minute_s10;
	logic [5:0]  second_s7, second_s8, second_s9, second_s10;

	logic [19:0] d675_full;
	logic [26:0] hour_prod;
	logic [16:0] r2_full;
	logic [20:0] min_prod;
	logic [11:0] sec_full;

	// only the low bits of days * 675 matter: the remainder is below 675
	assign d675_full = days_s1[9:0] * DAY_UNITS;
	assign hour_prod = rem_s3[16:4] * HOUR_RECIP;
	assign r2_full   = rem_s4 - 17'(hour_s4) * 17'd3600;
	assign min_prod  = r2_s5[11:2] * MIN_RECIP;
	assign sec_full  = r2_s6 - 12'(minute_s6) * 12'd60;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			lo_s1 <= sec_lo;
		end
		if (ctl.en[1]) begin
			lo_s2   <= lo_s1;
			d675_s2 <= d675_full[9:0];
		end
		if (ctl.en[2]) begin
			rem_s3 <= {lo_s2[16:7] - d675_s2, lo_s2[6:0]};
		end
		if (ctl.en[3]) begin
			rem_s4  <= rem_s3;
			hour_s4 <= hour_prod[25:21];
		end
		if (ctl.en[4]) begin
			r2_s5   <= r2_full[11:0];
			hour_s5 <= hour_s4;
		end
		if (ctl.en[5]) begin
			r2_s6     <= r2_s5;
			minute_s6 <= min_prod[19:14];
			hour_s6   <= hour_s5;
		end
		if (ctl.en[6]) begin
			second_s7 <= sec_full[5:0];
			minute_s7 <= minute_s6;
			hour_s7   <= hour_s6;
		end
		// delay to line up with the date lane
		if (ctl.en[7]) begin
			second_s8 <= second_s7;
			minute_s8 <= minute_s7;
			hour_s8   <= hour_s7;
		end
		if (ctl.en[8]) begin
			second_s9 <= second_s8;
			minute_s9 <= minute_s8;
			hour_s9   <= hour_s8;
		end
		if (ctl.en[9]) begin
			second_s10 <= second_s9;
			minute_s10 <= minute_s9;
			hour_s10   <= hour_s9;
		end
	end

	assign hour   = hour_s10;
	assign minute = minute_s10;
	assign second = second_s10;

endmodule

`default_nettype wire

[hdl/es2cd_date.sv]
// date lane: seconds to day count, then day count to Gregorian year, month, day
// depends on es2cd_pkg; hands the day count to the time lane
`default_nettype none

module es2cd_date import es2cd_pkg::*; (
	input  logic        clk,
	input  pipe_ctl_t   ctl,
	input  logic [35:0] epoch_seconds,
	output logic [19:0] days_s1,
	output logic [12:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day
);

	logic [20:0] z_s2;
	logic [2:0]  era_s2, era_s3, era_s4, era_s5, era_s6, era_s7, era_s8, era_s9;
	logic [17:0] doe_s3, doe_s4, doe_s5, doe_s6, doe_s7;
	logic [6:0]  q1460_s4;
	logic [2:0]  cent_s4;
	logic        last_s4;
	logic [17:0] n_s5;
	logic [8:0]  yoe_s6, yoe_s7, yoe_s8, yoe_s9;
	logic [17:0] y365_s7;
	logic [1:0]  c100_s7;
	logic [8:0]  doy_s8, doy_s9;
	logic [3:0]  mp_s9;
	logic [12:0] year_s10;
	logic [3:0]  month_s10;
	logic [4:0]  day_s10;

	logic [58:0] day_prod;
	logic [20:0] z_next;
	logic [2:0]  era_cnt;
	logic [20:0] doe_full;
	logic [32:0] q1460_prod;
	logic [2:0]  cent_cnt;
	logic [17:0] n_next;
	logic [36:0] year_prod;
	logic [1:0]  c100_cnt;
	logic [17:0] doy_full;
	logic [23:0] month_prod;
	logic [8:0]  day_full;
	logic [3:0]  month_next;
	logic [12:0] year_next;

	assign day_prod = epoch_seconds[35:7] * DAY_RECIP;
	assign z_next   = {1'b0, days_s1} + 21'(EPOCH_DAYS);

	// eras 0 to 3 lie before 1970, so only six boundaries remain
	always_comb begin
		era_cnt = '0;
		for (int i = 0; i < 6; i++) begin
			if (days_s1 >= era_thr(i)) begin
				era_cnt = era_cnt + 3'd1;
			end
		end
	end

	assign doe_full   = z_s2 - era_base(era_s2);
	assign q1460_prod = doe_s3[17:2] * Q1460_RECIP;

	always_comb begin
		cent_cnt = '0;
		for (int i = 1; i <= 4; i++) begin
			if (doe_s3 >= 18'(i * DAYS_PER_CENT)) begin
				cent_cnt = cent_cnt + 3'd1;
			end
		end
	end

	assign n_next    = doe_s4 - 18'(q1460_s4) + 18'(cent_s4) - 18'(last_s4);
	assign year_prod = n_s5 * YEAR_RECIP;
	assign c100_cnt  = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
	assign doy_full  = doe_s7 - y365_s7 - 18'(yoe_s7[8:2]) + 18'(c100_s7);
	assign month_prod = 24'(doy_s8) * 24'(MONTH_MUL) + MONTH_ADD;

	// month index counts from March, so January and February roll the year
	assign day_full   = doy_s9 - month_start(mp_s9) + 9'd1;
	assign month_next = (mp_s9 < 4'd10) ? 4'(mp_s9 + 4'd3) : 4'(mp_s9 - 4'd9);
	assign year_next  = 13'(yoe_s9) + era_year(era_s9) + 13'(month_next <= 4'd2);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			days_s1 <= day_prod[58:39];
		end
		if (ctl.en[1]) begin
			z_s2   <= z_next;
			era_s2 <= era_cnt;
		end
		if (ctl.en[2]) begin
			doe_s3 <= doe_full[17:0];
			era_s3 <= era_s2;
		end
		if (ctl.en[3]) begin
			doe_s4   <= doe_s3;
			q1460_s4 <= q1460_prod[31:25];
			cent_s4  <= cent_cnt;
			last_s4  <= (doe_s3 == 18'(DAYS_PER_ERA - 1));
			era_s4   <= era_s3;
		end
		if (ctl.en[4]) begin
			n_s5   <= n_next;
			doe_s5 <= doe_s4;
			era_s5 <= era_s4;
		end
		if (ctl.en[5]) begin
			yoe_s6 <= year_prod[35:27];
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
		end
		if (ctl.en[6]) begin
			y365_s7 <= 18'(yoe_s6) * 18'd365;
			c100_s7 <= c100_cnt;
			yoe_s7  <= yoe_s6;
			doe_s7  <= doe_s6;
			era_s7  <= era_s6;
		end
		if (ctl.en[7]) begin
			doy_s8 <= doy_full[8:0];
			yoe_s8 <= yoe_s7;
			era_s8 <= era_s7;
		end
		if (ctl.en[8]) begin
			mp_s9  <= month_prod[22:19];
			doy_s9 <= doy_s8;
			yoe_s9 <= yoe_s8;
			era_s9 <= era_s8;
		end
		if (ctl.en[9]) begin
			year_s10  <= year_next;
			month_s10 <= month_next;
			day_s10   <= day_full[4:0];
		end
	end

	assign year  = year_s10;
	assign month = month_s10;
	assign day   = day_s10;

endmodule

`default_nettype wire

[hdl/epoch_seconds_to_calendar_date.sv]
// Converts a 36-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian year, month, day, hour, minute and second (full century rule, no
// leap seconds). Every input value gives a valid date up to year 4147. The
// block is a ten-stage pipeline: a result is registered through stages s1 to
// s10 before it shows on the output, and a new request is taken every cycle
// while the output is drained. Each stage loads whenever it or a later stage
// has room, so bubbles close up during an output stall. Depends on es2cd_pkg,
// es2cd_ctrl, es2cd_time, es2cd_date.
`default_nettype none
`include "epoch_seconds_to_calendar_date_assert.svh"

module epoch_seconds_to_calendar_date import es2cd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [35:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [12:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	pipe_ctl_t   ctl;
	logic [19:0] days_s1;

	es2cd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	es2cd_date u_date (
		.clk           (clk),
		.ctl           (ctl),
		.epoch_seconds (epoch_seconds),
		.days_s1       (days_s1),
		.year          (year),
		.month         (month),
		.day           (day)
	);

	es2cd_time u_time (
		.clk     (clk),
		.ctl     (ctl),
		.sec_lo  (epoch_seconds[16:0]),
		.days_s1 (days_s1),
		.hour    (hour),
		.minute  (minute),
		.second  (second)
	);

	`ES2CD_ASSERT_IMP(a_out_range, out_valid, (month != 4'd0) && (month <= 4'd12) && (day != 5'd0) && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59), "result field out of range")

endmodule

`default_nettype wire

[test/epoch_seconds_to_calendar_date_tb.sv]
`timescale 1ns / 100ps
// testbench for epoch_seconds_to_calendar_date: drives second counts and checks each date
// against a behavioral civil-calendar model, with random idles on both handshakes
// depends only on the epoch_seconds_to_calendar_date rtl

module epoch_seconds_to_calendar_date_tb;

	localparam longint unsigned SECS_PER_DAY = 86400;
	localparam longint unsigned ERA_DAYS = 146097;       // days in 400 gregorian years
	localparam longint unsigned MARCH0_TO_EPOCH = 719468; // 0000-03-01 .. 1970-01-01
	localparam longint unsigned MAX_DAYS = 795364;       // last day a 36-bit count reaches
	localparam int N_RANDOM = 1000;
	localparam int IDLE_PCT = 28;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 80;
	localparam int CALM_FROM = 500;
	localparam int CALM_TO = 700;
	localparam int TAIL_CYCLES = 30;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [12:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_date_t;

	typedef struct {
		logic [35:0] secs;
		bit          drain_first;   // hold the request back until all dates are in
	} secs_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [35:0] epoch_seconds = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [12:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	secs_req_t pending_secs[$];
	cal_date_t expected_dates[$];
	bit        req_taken = 1'b0;
	int        req_count = 0;
	int        date_count = 0;
	int        input_stalls = 0;
	int        error_count = 0;
	int        cycle_count = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;

	epoch_seconds_to_calendar_date i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// day count shifted to start on 1 march so that the leap day ends each year
	function automatic cal_date_t civil_date(input logic [35:0] secs);
		longint unsigned days, tod, shifted, era, day_of_era, year_of_era, day_of_year;
		longint unsigned mon_idx, mon, yr;
		cal_date_t res;
		days = longint'(secs) / SECS_PER_DAY;
		tod = longint'(secs) % SECS_PER_DAY;
		shifted = days + MARCH0_TO_EPOCH;
		era = shifted / ERA_DAYS;
		day_of_era = shifted - era * ERA_DAYS;
		year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
			- day_of_era / 146096) / 365;
		day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
		mon_idx = (5 * day_of_year + 2) / 153;
		mon = (mon_idx < 10) ? mon_idx + 3 : mon_idx - 9;
		yr = year_of_era + era * 400 + ((mon <= 2) ? 1 : 0);
		res.year = 13'(yr);
		res.month = 4'(mon);
		res.day = 5'(day_of_year - (153 * mon_idx + 2) / 5 + 1);
		res.hour = 5'(tod / 3600);
		res.minute = 6'((tod % 3600) / 60);
		res.second = 6'(tod % 60);
		return res;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			error_count++;
		end
	endtask

	task automatic add_secs(input logic [35:0] secs, input bit drain_first);
		secs_req_t req;
		req.secs = secs;
		req.drain_first = drain_first;
		pending_secs.push_back(req);
	endtask

	function automatic bit calm_phase();
		return req_count >= CALM_FROM && req_count < CALM_TO;
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (pending_secs.size() > 0
					&& !(pending_secs[0].drain_first && expected_dates.size() > 0)
					&& (calm_phase() || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				epoch_seconds <= pending_secs[0].secs;
				pending_secs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off so the pipeline backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && req_count >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm_phase() || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		cal_date_t exp_date;
		req_taken = in_valid && in_ready;
		if (in_valid && !in_ready)
			input_stalls++;
		if (req_taken) begin
			expected_dates.push_back(civil_date(epoch_seconds));
			req_count++;
		end
		if (out_valid && out_ready) begin
			date_count++;
			if (expected_dates.size() == 0) begin
				$error("date returned with no request outstanding");
				error_count++;
			end else begin
				exp_date = expected_dates.pop_front();
				check_field("year", 32'(exp_date.year), 32'(year));
				check_field("month", 32'(exp_date.month), 32'(month));
				check_field("day", 32'(exp_date.day), 32'(day));
				check_field("hour", 32'(exp_date.hour), 32'(hour));
				check_field("minute", 32'(exp_date.minute), 32'(minute));
				check_field("second", 32'(exp_date.second), 32'(second));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d dates outstanding", cycle_count,
				expected_dates.size());
			$display("epoch_seconds_to_calendar_date verification failed");
			$finish;
		end
	end

	initial begin
		longint unsigned pick_days;
		logic [35:0] secs;
		int kind;

		// directed: extremes, day and year edges, century leap rules
		add_secs(36'd0, 1'b0);
		add_secs(36'hFFFFFFFFF, 1'b0);
		add_secs(36'd1, 1'b0);
		add_secs(36'd59, 1'b0);
		add_secs(36'd3599, 1'b0);
		add_secs(36'd86399, 1'b0);
		add_secs(36'd86400, 1'b0);
		add_secs(36'd31535999, 1'b0);      // 1970-12-31 23:59:59
		add_secs(36'd31536000, 1'b0);      // 1971-01-01
		add_secs(36'd946684799, 1'b0);     // last second of 1999
		add_secs(36'd946684800, 1'b0);
		add_secs(36'd951782400, 1'b0);     // 2000-02-29
		add_secs(36'd951868800, 1'b0);     // 2000-03-01
		add_secs(36'd4107542399, 1'b0);    // 2100-02-28 23:59:59, no leap day
		add_secs(36'd4107542400, 1'b0);    // 2100-03-01
		add_secs(36'd13574563200, 1'b0);   // 2400-02-29
		add_secs(36'd13574649599, 1'b0);
		add_secs(36'h800000000, 1'b0);
		add_secs(36'h7FFFFFFFF, 1'b0);
		add_secs(36'h555555555, 1'b0);
		add_secs(36'hAAAAAAAAA, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(3);
			if (kind < 2) begin
				secs = 36'({$urandom, $urandom});
			end else if (kind == 2) begin
				secs = 36'($urandom);
			end else begin
				// land just around a midnight
				pick_days = $urandom_range(32'(MAX_DAYS));
				secs = 36'(pick_days * SECS_PER_DAY + $urandom_range(4) - 2);
			end
			add_secs(secs, i == 0 || i == 800);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_secs.size() == 0 && !in_valid && expected_dates.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("converted %0d second counts to dates, %0d checked, in %0d cycles",
			req_count, date_count, cycle_count);
		$display("input held off for %0d cycles while the output was stalled", input_stalls);
		if (error_count == 0 && expected_dates.size() == 0) begin
			$display("epoch_seconds_to_calendar_date verification clean");
		end else begin
			$display("epoch_seconds_to_calendar_date verification failed");
		end
		$finish;
	end

endmodule
